FILE: rtl/pctg_pkg.sv
`timescale 1ns / 1ps
// package for the polynomial counter tone generator
// holds field widths, register indexes, tone mode codes and shared types; no dependencies

package pctg_pkg;

  // field widths
  localparam int unsigned HcntW    = 8;
  localparam int unsigned CtlW     = 4;
  localparam int unsigned DivW     = 5;
  localparam int unsigned VolW     = 4;
  localparam int unsigned MixW     = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned ThirdW   = 2;
  localparam int unsigned Poly4W   = 4;
  localparam int unsigned Poly5W   = 5;
  localparam int unsigned Poly9W   = 9;

  // line positions at which the channels advance
  localparam logic [HcntW-1:0] HPOS_FIRST  = 8'd0;
  localparam logic [HcntW-1:0] HPOS_SECOND = 8'd114;

  // divide-by-three counter wraps at this value
  localparam logic [ThirdW-1:0] THIRD_WRAP = 2'd3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CONTROL_A = 3'd0,
    REG_CONTROL_B = 3'd1,
    REG_DIVIDER_A = 3'd2,
    REG_DIVIDER_B = 3'd3,
    REG_VOLUME_A  = 3'd4,
    REG_VOLUME_B  = 3'd5
  } cfg_reg_e;

  // tone modes selected by the 4-bit control
  typedef enum logic [CtlW-1:0] {
    MODE_FILL             = 4'h0,
    MODE_POLY4            = 4'h1,
    MODE_POLY4_GATED      = 4'h2,
    MODE_POLY4_CLK5       = 4'h3,
    MODE_FILL4_TOGGLE     = 4'h4,
    MODE_FILL5_TOGGLE     = 4'h5,
    MODE_POLY5_HOLD       = 4'h6,
    MODE_POLY5            = 4'h7,
    MODE_POLY9            = 4'h8,
    MODE_POLY5_ALT        = 4'h9,
    MODE_POLY5_HOLD_ALT   = 4'hA,
    MODE_FILL_ALT         = 4'hB,
    MODE_TOGGLE_DIV3      = 4'hC,
    MODE_TOGGLE_DIV3_ALT  = 4'hD,
    MODE_POLY5_HOLD_DIV3  = 4'hE,
    MODE_POLY5_DIV3       = 4'hF
  } tone_mode_e;

  // per-channel settings handed to a channel
  typedef struct packed {
    logic [CtlW-1:0] control;
    logic [DivW-1:0] divider;
  } chan_cfg_t;

endpackage

FILE: rtl/pctg_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the tone generator: tick input, result output
// and configuration write; depends on pctg_pkg

interface pctg_tick_if;
  logic                        valid;
  logic                        ready;
  logic [pctg_pkg::HcntW-1:0]  hcounter;

  modport source (output valid, output hcounter, input ready);
  modport sink   (input valid, input hcounter, output ready);
endinterface

interface pctg_result_if;
  logic                        valid;
  logic                        ready;
  logic                        sample_a;
  logic                        sample_b;
  logic [pctg_pkg::VolW-1:0]   level_a;
  logic [pctg_pkg::VolW-1:0]   level_b;
  logic [pctg_pkg::MixW-1:0]   mix_level;

  modport source (output valid, output sample_a, output sample_b, output level_a,
                  output level_b, output mix_level, input ready);
  modport sink   (input valid, input sample_a, input sample_b, input level_a,
                  input level_b, input mix_level, output ready);
endinterface

interface pctg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pctg_pkg::CfgIdxW-1:0]  index;
  logic [pctg_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/poly_counter_tone_generator.sv
`timescale 1ns / 1ps
// top level of the two-channel polynomial counter tone generator
// depends on pctg_pkg, pctg_if and pctg_channel
//
// Usage
//   tick_i   : one beat per horizontal counter step, carrying hcounter. Only
//              positions 0 and 114 advance the channels; every beat still
//              gives one result beat.
//   result_o : both one-bit samples, the volume-weighted levels and their sum,
//              as they stand after the tick has been applied.
//   cfg_i    : register writes, index 0..5 = control_a, control_b, divider_a,
//              divider_b, volume_a, volume_b; always ready, other indexes ignored.
//              Write only while no tick is in flight.
// Timing
//   a tick is held in the input register, then the channel update and level
//   sum are loaded into the result register, which drives result_o; one tick
//   per cycle sustained while the receiver is ready, set by the single channel
//   update stage. When the receiver stalls the result register holds; the
//   input register still takes one more beat if it is empty, then
//   tick_i.ready drops until the stall clears.
// Reset
//   configuration registers, valid flags and channel counters clear; polynomial
//   counters load all ones; both pipeline stages empty; data registers not reset.

module poly_counter_tone_generator (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  pctg_tick_if.sink              tick_i,
  pctg_cfg_if.sink               cfg_i,
  pctg_result_if.source          result_o
);

  // configuration registers
  logic [pctg_pkg::CtlW-1:0] control_a_q, control_b_q;
  logic [pctg_pkg::DivW-1:0] divider_a_q, divider_b_q;
  logic [pctg_pkg::VolW-1:0] volume_a_q, volume_b_q;

  // pipeline registers
  logic                       in_valid_q;
  logic [pctg_pkg::HcntW-1:0] in_hcnt_q;
  logic                       out_valid_q;
  logic                       sample_a_q, sample_b_q;
  logic [pctg_pkg::VolW-1:0]  level_a_q, level_b_q;
  logic [pctg_pkg::MixW-1:0]  mix_q;

  logic                       out_take;
  logic                       fire;
  logic                       advance;
  logic                       bit_a_d, bit_b_d;
  logic [pctg_pkg::VolW-1:0]  level_a_d, level_b_d;
  pctg_pkg::chan_cfg_t        cfg_a, cfg_b;

  // configuration write port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_a_q <= '0;
      control_b_q <= '0;
      divider_a_q <= '0;
      divider_b_q <= '0;
      volume_a_q  <= '0;
      volume_b_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (pctg_pkg::cfg_reg_e'(cfg_i.index))
        pctg_pkg::REG_CONTROL_A: control_a_q <= cfg_i.data[pctg_pkg::CtlW-1:0];
        pctg_pkg::REG_CONTROL_B: control_b_q <= cfg_i.data[pctg_pkg::CtlW-1:0];
        pctg_pkg::REG_DIVIDER_A: divider_a_q <= cfg_i.data[pctg_pkg::DivW-1:0];
        pctg_pkg::REG_DIVIDER_B: divider_b_q <= cfg_i.data[pctg_pkg::DivW-1:0];
        pctg_pkg::REG_VOLUME_A:  volume_a_q  <= cfg_i.data[pctg_pkg::VolW-1:0];
        pctg_pkg::REG_VOLUME_B:  volume_b_q  <= cfg_i.data[pctg_pkg::VolW-1:0];
        default: begin
          control_a_q <= control_a_q;
        end
      endcase
    end
  end

  // handshake between the two stages
  assign out_take     = !out_valid_q || result_o.ready;
  assign fire         = in_valid_q && out_take;
  assign tick_i.ready = !in_valid_q || out_take;
  assign advance      = fire && (in_hcnt_q == pctg_pkg::HPOS_FIRST ||
                                 in_hcnt_q == pctg_pkg::HPOS_SECOND);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (tick_i.ready) begin
      in_valid_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      in_hcnt_q <= tick_i.hcounter;
    end
  end

  // the two channels
  assign cfg_a = '{control: control_a_q, divider: divider_a_q};
  assign cfg_b = '{control: control_b_q, divider: divider_b_q};

  pctg_channel u_chan_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_a),
    .advance_i   (advance),
    .out_bit_d_o (bit_a_d)
  );

  pctg_channel u_chan_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_b),
    .advance_i   (advance),
    .out_bit_d_o (bit_b_d)
  );

  // volume weighting
  assign level_a_d = bit_a_d ? volume_a_q : '0;
  assign level_b_d = bit_b_d ? volume_b_q : '0;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      sample_a_q <= bit_a_d;
      sample_b_q <= bit_b_d;
      level_a_q  <= level_a_d;
      level_b_q  <= level_b_d;
      mix_q      <= {1'b0, level_a_d} + {1'b0, level_b_d};
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.sample_a  = sample_a_q;
  assign result_o.sample_b  = sample_b_q;
  assign result_o.level_a   = level_a_q;
  assign result_o.level_b   = level_b_q;
  assign result_o.mix_level = mix_q;

  // checks
  a_mix_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (mix_q == {1'b0, level_a_q} + {1'b0, level_b_q}))
    else $error("mix level differs from sum of channel levels");

  a_level_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((sample_a_q || level_a_q == '0) && (sample_b_q || level_b_q == '0)))
    else $error("level present on a silent channel");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_take) |=> (in_valid_q && $stable(in_hcnt_q)))
    else $error("stalled tick lost from input register");

  a_no_advance_off_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !advance) |=> (sample_a_q == $past(bit_a_d) && sample_b_q == $past(bit_b_d)))
    else $error("result not taken from channel state");

endmodule

FILE: rtl/pctg_channel.sv
`timescale 1ns / 1ps
// one tone channel: phase divider, divide-by-three and polynomial counters
// depends on pctg_pkg

module pctg_channel (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pctg_pkg::chan_cfg_t  cfg_i,
  input  logic                 advance_i,
  output logic                 out_bit_d_o
);

  localparam int unsigned Poly4Top = pctg_pkg::Poly4W - 1;
  localparam int unsigned Poly5Top = pctg_pkg::Poly5W - 1;
  localparam int unsigned Poly9Top = pctg_pkg::Poly9W - 1;

  logic [pctg_pkg::DivW-1:0]   phase_q, phase_d;
  logic [pctg_pkg::ThirdW-1:0] third_q, third_d;
  logic [pctg_pkg::Poly4W-1:0] poly4_q, poly4_d;
  logic [pctg_pkg::Poly5W-1:0] poly5_q, poly5_d;
  logic [pctg_pkg::Poly9W-1:0] poly9_q, poly9_d;
  logic                        toggle_q, toggle_d;
  logic                        out_q, out_d;

  logic [pctg_pkg::Poly4W-1:0] step4, fill4;
  logic [pctg_pkg::Poly5W-1:0] step5, fill5;
  logic [pctg_pkg::Poly9W-1:0] step9;
  logic [pctg_pkg::ThirdW-1:0] third_inc;
  logic                        div3_mode;
  logic                        run_mode;
  pctg_pkg::tone_mode_e        mode;

  // shift candidates of each counter, fill candidates of the 4- and 5-bit counters
  assign step4 = {poly4_q[1] ^ poly4_q[0], poly4_q[Poly4Top:1]};
  assign fill4 = {1'b1, poly4_q[Poly4Top:1]};
  assign step5 = {poly5_q[2] ^ poly5_q[0], poly5_q[Poly5Top:1]};
  assign fill5 = {1'b1, poly5_q[Poly5Top:1]};
  assign step9 = {poly9_q[4] ^ poly9_q[0], poly9_q[Poly9Top:1]};

  assign mode      = pctg_pkg::tone_mode_e'(cfg_i.control);
  assign div3_mode = (cfg_i.control >= pctg_pkg::MODE_TOGGLE_DIV3);
  assign third_inc = third_q + 2'd1;

  // divider, divide-by-three and mode logic
  always_comb begin
    phase_d  = phase_q;
    third_d  = third_q;
    poly4_d  = poly4_q;
    poly5_d  = poly5_q;
    poly9_d  = poly9_q;
    toggle_d = toggle_q;
    out_d    = out_q;
    run_mode = 1'b0;

    if (advance_i) begin
      if (phase_q < cfg_i.divider) begin
        phase_d = phase_q + 5'd1;
      end else begin
        phase_d = '0;
        if (div3_mode) begin
          if (third_inc == pctg_pkg::THIRD_WRAP) begin
            third_d  = '0;
            run_mode = 1'b1;
          end else begin
            third_d = third_inc;
          end
        end else begin
          run_mode = 1'b1;
        end
      end
    end

    if (run_mode) begin
      unique case (mode)
        pctg_pkg::MODE_FILL, pctg_pkg::MODE_FILL_ALT: begin
          out_d   = poly4_q[0];
          poly4_d = fill4;
          poly5_d = fill5;
        end
        pctg_pkg::MODE_POLY4: begin
          out_d   = poly4_q[0];
          poly4_d = step4;
        end
        pctg_pkg::MODE_POLY4_GATED: begin
          if (poly5_q[3:0] == 4'h0 || poly5_q[3:0] == 4'hF) begin
            out_d   = poly4_q[0];
            poly4_d = step4;
          end
          poly5_d = step5;
        end
        pctg_pkg::MODE_POLY4_CLK5: begin
          if (poly5_q[0]) begin
            out_d   = poly4_q[0];
            poly4_d = step4;
          end
          poly5_d = step5;
        end
        pctg_pkg::MODE_FILL4_TOGGLE: begin
          poly4_d  = fill4;
          poly5_d  = step5;
          out_d    = toggle_q;
          toggle_d = ~toggle_q;
        end
        pctg_pkg::MODE_FILL5_TOGGLE: begin
          poly5_d  = fill5;
          poly4_d  = step4;
          out_d    = toggle_q;
          toggle_d = ~toggle_q;
        end
        pctg_pkg::MODE_POLY5_HOLD, pctg_pkg::MODE_POLY5_HOLD_ALT,
        pctg_pkg::MODE_POLY5_HOLD_DIV3: begin
          poly5_d = step5;
          if (step5[3:0] == 4'h0) out_d = 1'b0;
          if (step5[3:0] == 4'hF) out_d = 1'b1;
        end
        pctg_pkg::MODE_POLY5, pctg_pkg::MODE_POLY5_ALT, pctg_pkg::MODE_POLY5_DIV3: begin
          out_d   = poly5_q[0];
          poly5_d = step5;
        end
        pctg_pkg::MODE_POLY9: begin
          out_d   = poly9_q[0];
          poly9_d = step9;
        end
        pctg_pkg::MODE_TOGGLE_DIV3, pctg_pkg::MODE_TOGGLE_DIV3_ALT: begin
          out_d    = toggle_q;
          toggle_d = ~toggle_q;
        end
        default: begin
          out_d = out_q;
        end
      endcase
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      third_q  <= '0;
      poly4_q  <= '1;
      poly5_q  <= '1;
      poly9_q  <= '1;
      toggle_q <= 1'b0;
      out_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      third_q  <= third_d;
      poly4_q  <= poly4_d;
      poly5_q  <= poly5_d;
      poly9_q  <= poly9_d;
      toggle_q <= toggle_d;
      out_q    <= out_d;
    end
  end

  assign out_bit_d_o = out_d;

endmodule
